// File: rtl/core/pmr_pkg.sv
// Shared constants, types and arithmetic helpers of the Lehmer range generator.
`default_nettype none
package pmr_pkg;

  localparam int unsigned BOUND_W = 16;
  localparam int unsigned STATE_W = 31;
  localparam int unsigned SPAN_W  = BOUND_W + 1;
  localparam int unsigned PROD_W  = STATE_W + SPAN_W;
  localparam int unsigned MUL_W   = 15;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [STATE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [MUL_W-1:0]   LEHMER_MUL = 15'd16807;
  localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;

  // one classified word waiting for the range mapping
  typedef struct packed {
    logic signed [BOUND_W-1:0] low_bound;
    logic [SPAN_W-1:0]         span;
    logic                      bad_range;
    logic [STATE_W-1:0]        new_state;
  } job_t;

  // seed load request toward the generator state
  typedef struct packed {
    logic               load;
    logic [STATE_W-1:0] seed;
  } seed_load_t;

  // zero and the modulus itself would lock the generator; load 1 instead
  function automatic logic [STATE_W-1:0] load_seed(input logic [STATE_W-1:0] v);
    logic [STATE_W-1:0] s;
    s = v;
    if (v == LEHMER_MOD || v == '0) begin
      s = SEED_RESET;
    end
    return s;
  endfunction

  // state * 16807 mod (2^31 - 1), Mersenne fold with one correction
  function automatic logic [STATE_W-1:0] lehmer_advance(input logic [STATE_W-1:0] s);
    logic [STATE_W+MUL_W-1:0] p;
    logic [STATE_W:0]         sum;
    p   = (STATE_W+MUL_W)'(s) * (STATE_W+MUL_W)'(LEHMER_MUL);
    sum = (STATE_W+1)'(p[STATE_W+MUL_W-1:STATE_W]) + (STATE_W+1)'(p[STATE_W-1:0]);
    if (sum >= {1'b0, LEHMER_MOD}) begin
      sum = sum - {1'b0, LEHMER_MOD};
    end
    return sum[STATE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pmr_if.sv
// Handshake interfaces for the bound-pair input and the draw result words.
`default_nettype none
interface pmr_in_if;
  import pmr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [BOUND_W-1:0] low_bound;
  logic signed [BOUND_W-1:0] high_bound;
  modport source (output valid, low_bound, high_bound, input ready);
  modport sink   (input valid, low_bound, high_bound, output ready);
endinterface

interface pmr_out_if;
  import pmr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [BOUND_W-1:0] draw_value;
  logic [STATE_W-1:0]        new_state;
  logic                      bad_range;
  modport source (output valid, draw_value, new_state, bad_range, input ready);
  modport sink   (input valid, draw_value, new_state, bad_range, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pmr_front.sv
// Front end: takes bound pairs, advances the generator, classifies the range.
`default_nettype none
module pmr_front (
  input  wire                 clk,
  input  wire                 rst_n,
  pmr_in_if.sink              in_word,
  input  pmr_pkg::seed_load_t seed_load,
  output pmr_pkg::job_t       push_job,
  output logic                push_valid,
  input  wire                 push_ready
);
  import pmr_pkg::*;

  logic [STATE_W-1:0]      state_r;
  logic [STATE_W-1:0]      state_nxt;
  logic signed [SPAN_W-1:0] diff;
  logic                    accept;

  assign in_word.ready = push_ready;
  assign accept        = in_word.valid & push_ready;
  assign push_valid    = in_word.valid;

  assign state_nxt = lehmer_advance(state_r);
  assign diff      = SPAN_W'(in_word.high_bound) - SPAN_W'(in_word.low_bound);

  always_comb begin
    push_job.low_bound = in_word.low_bound;
    push_job.bad_range = diff[SPAN_W-1];
    push_job.span      = diff[SPAN_W-1] ? '0 : SPAN_W'(diff) + SPAN_W'(1);
    push_job.new_state = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= load_seed(SEED_RESET);
    end else if (seed_load.load) begin
      state_r <= load_seed(seed_load.seed);
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pmr_queue.sv
// Two-entry queue decoupling the front end from the range mapper.
`default_nettype none
module pmr_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  pmr_pkg::job_t push_job,
  input  wire           push_valid,
  output logic          push_ready,
  output pmr_pkg::job_t pop_job,
  output logic          pop_valid,
  input  wire           pop_ready
);
  import pmr_pkg::*;

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pmr_back.sv
// Back end: maps the state onto the range, floor(state*span/(2^31-1)).
`default_nettype none
module pmr_back (
  input  wire           clk,
  input  wire           rst_n,
  input  pmr_pkg::job_t pop_job,
  input  wire           pop_valid,
  output logic          pop_ready,
  pmr_out_if.source     out_word
);
  import pmr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FOLD, S_HOLD} state_t;

  state_t                    state_r;
  job_t                      job_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      out_valid_r;
  logic signed [BOUND_W-1:0] draw_r;
  logic [STATE_W-1:0]        new_state_r;
  logic                      bad_r;

  logic [SPAN_W-1:0]         quo_hi;
  logic [STATE_W:0]          fold_sum;
  logic [SPAN_W-1:0]         quo;
  logic signed [BOUND_W-1:0] draw_nxt;
  logic                      take;

  // P = a*2^31 + b = a*M + (a + b); a + b stays below 2M
  assign quo_hi   = prod_r[PROD_W-1:STATE_W];
  assign fold_sum = (STATE_W+1)'(quo_hi) + (STATE_W+1)'(prod_r[STATE_W-1:0]);
  assign quo      = quo_hi + SPAN_W'(fold_sum >= {1'b0, LEHMER_MOD});
  assign draw_nxt = job_r.bad_range ? job_r.low_bound
                                    : job_r.low_bound + BOUND_W'(quo);

  assign pop_ready = (state_r == S_IDLE) || (state_r == S_HOLD && out_word.ready);
  assign take      = pop_valid & pop_ready;

  assign out_word.valid      = out_valid_r;
  assign out_word.draw_value = draw_r;
  assign out_word.new_state  = new_state_r;
  assign out_word.bad_range  = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            job_r   <= pop_job;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(job_r.new_state) * PROD_W'(job_r.span);
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          draw_r      <= draw_nxt;
          new_state_r <= job_r.new_state;
          bad_r       <= job_r.bad_range;
          out_valid_r <= 1'b1;
          state_r     <= S_HOLD;
        end
        S_HOLD: begin
          if (out_word.ready) begin
            out_valid_r <= 1'b0;
            if (take) begin
              job_r   <= pop_job;
              state_r <= S_MUL;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/park_miller_range_rng.sv
// Top level of the minimal-standard Lehmer generator with range mapping.
// An accepted word is registered in the queue, then in the back end's job, product and result registers.
// The back end takes the next word only once its result word has been accepted.
// The front end accepts up to two words ahead through the queue.
// Reset (synchronous, rst_n low): seed_start = 1, generator state = 1, queue
// and result register empty.
`default_nettype none
module park_miller_range_rng (
  input  wire         clk,
  input  wire         rst_n,
  pmr_in_if.sink      in_word,
  pmr_out_if.source   out_word,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pmr_pkg::*;

  // register index lives above the byte offset
  localparam logic REG_SEED_START = 1'b0;

  logic [STATE_W-1:0] seed_r;
  logic               cfg_wr;
  seed_load_t         seed_load;

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  // APB: zero wait states; write lands on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SEED_START);
  assign prdata = (paddr[2] == REG_SEED_START) ? 32'(seed_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr) begin
      seed_r <= pwdata[STATE_W-1:0];
    end
  end

  // a seed write also reloads the generator state
  always_comb begin
    seed_load.load = cfg_wr;
    seed_load.seed = pwdata[STATE_W-1:0];
  end

  // front: accept, advance state, classify range
  pmr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .seed_load  (seed_load),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decoupling queue
  pmr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // back: range mapping and result register
  pmr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// File: rtl/core/pmr_checker.sv
// Port-level checks on the range generator, bound to the top level.
`default_nettype none
module pmr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_draw_value,
  input wire [30:0] out_new_state,
  input wire        out_bad_range,
  input wire        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_draw_value) && $stable(out_new_state)
      && $stable(out_bad_range))
    else $error("result word changed while stalled");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_new_state != 31'd0 && out_new_state != 31'h7FFF_FFFF)
    else $error("generator state left 1..2^31-2");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("config port inserted a wait state");

endmodule

bind park_miller_range_rng pmr_checker u_pmr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .out_draw_value (out_word.draw_value),
  .out_new_state  (out_word.new_state),
  .out_bad_range  (out_word.bad_range),
  .pready         (pready)
);
`default_nettype wire
